// ===== hdl/ftfe_pkg.sv =====
// ----------------------------------------------------------------------------
// ftfe_pkg: shared types and constants of the flow table
// Table geometry, the entry word held by each cell and the controller states.
// ----------------------------------------------------------------------------
package ftfe_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              family;
        logic [63:0]       addr_high;
        logic [63:0]       addr_low;
        logic [15:0]       port;
        logic [DATA_W-1:0] data;
    } ftfe_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INSERT,
        ST_DONE
    } ftfe_state_t;

endpackage

// ===== hdl/flow_table_fifo_evict.sv =====
// ----------------------------------------------------------------------------
// flow_table_fifo_evict: flow table with first-in first-out replacement
// Associative table of flow keys with one data word per entry.
// ----------------------------------------------------------------------------
// The table is a ring of CAPACITY cells ordered by insertion age, oldest at
// the head. One request is handled at a time. The ring rotates one entry per
// cycle past the single key comparator at its head and returns to its
// starting position after a full turn; for an add that misses, the key is
// then shifted in at the tail, pushing the oldest entry out when the table
// is full. The result word then goes to the output register, and the next
// request is taken only once it has been loaded there. A result word may
// wait in the output register while the next request is taken.
module flow_table_fifo_evict
    import ftfe_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  logic              s_is_v6,
    input  logic [63:0]       s_ip_high,
    input  logic [63:0]       s_ip_low,
    input  logic [15:0]       s_port,
    input  logic [DATA_W-1:0] s_entry_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_found,
    output logic [DATA_W-1:0] m_read_data,
    output logic              m_evicted
);

    ftfe_entry_t chain [CAPACITY];
    ftfe_entry_t tail_in;
    logic        shift_en;

    ftfe_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_is_v6      (s_is_v6),
        .s_ip_high    (s_ip_high),
        .s_ip_low     (s_ip_low),
        .s_port       (s_port),
        .s_entry_data (s_entry_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_read_data  (m_read_data),
        .m_evicted    (m_evicted),
        .head         (chain[0]),
        .tail_in      (tail_in),
        .shift_en     (shift_en)
    );

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == CAPACITY - 1) begin : g_tail
            ftfe_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .shift_en  (shift_en),
                .entry_in  (tail_in),
                .entry_out (chain[i])
            );
        end else begin : g_body
            ftfe_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .shift_en  (shift_en),
                .entry_in  (chain[i+1]),
                .entry_out (chain[i])
            );
        end
    end

endmodule

// ===== hdl/ftfe_cell.sv =====
// ----------------------------------------------------------------------------
// ftfe_cell: one table entry in the rotating chain
// Holds one entry and takes its neighbour's entry on every shift.
// ----------------------------------------------------------------------------
module ftfe_cell
    import ftfe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        shift_en,
    input  ftfe_entry_t entry_in,
    output ftfe_entry_t entry_out
);

    logic        valid_reg;
    ftfe_entry_t body_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= entry_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            body_reg <= entry_in;
        end
    end

    always_comb begin
        entry_out       = body_reg;
        entry_out.valid = valid_reg;
    end

endmodule

// ===== hdl/ftfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// ftfe_ctrl: request sequencer and head comparator
// Takes a request, rotates the chain once past the head compare, inserts on
// an add miss and hands the result word to the output register.
// ----------------------------------------------------------------------------
module ftfe_ctrl
    import ftfe_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  logic              s_is_v6,
    input  logic [63:0]       s_ip_high,
    input  logic [63:0]       s_ip_low,
    input  logic [15:0]       s_port,
    input  logic [DATA_W-1:0] s_entry_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_found,
    output logic [DATA_W-1:0] m_read_data,
    output logic              m_evicted,
    input  ftfe_entry_t       head,
    output ftfe_entry_t       tail_in,
    output logic              shift_en
);

    ftfe_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg;
    logic              op_reg;
    ftfe_entry_t       key_reg;
    logic              hit_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic              evict_reg;
    logic              m_valid_reg;
    logic              m_found_reg;
    logic [DATA_W-1:0] m_read_data_reg;
    logic              m_evicted_reg;

    logic head_match;
    logic last_step;
    logic out_free;

    assign head_match = head.valid && (head.family == key_reg.family) &&
                        (head.addr_high == key_reg.addr_high) &&
                        (head.addr_low == key_reg.addr_low) &&
                        (head.port == key_reg.port);
    assign last_step  = (cnt_reg == IDX_W'(CAPACITY - 1));
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (last_step) begin
                    if (op_reg == OP_ADD && !(hit_reg || head_match)) begin
                        state_next = ST_INSERT;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_INSERT: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        shift_en = 1'b0;
        tail_in  = key_reg;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_SCAN: begin
                // wrap the head round to the tail, rewriting data on an add hit
                shift_en = 1'b1;
                tail_in  = head;
                if (head_match && op_reg == OP_ADD) tail_in.data = key_reg.data;
            end
            ST_INSERT: shift_en = 1'b1;
            ST_DONE:   ;
            default:   ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            op_reg            <= s_operation;
            key_reg.valid     <= 1'b1;
            key_reg.family    <= s_is_v6;
            key_reg.addr_high <= s_is_v6 ? s_ip_high : 64'd0;
            key_reg.addr_low  <= s_is_v6 ? s_ip_low : {32'd0, s_ip_low[31:0]};
            key_reg.port      <= s_port;
            key_reg.data      <= s_entry_data;
            cnt_reg           <= '0;
            hit_reg           <= 1'b0;
            evict_reg         <= 1'b0;
        end else if (state_reg == ST_SCAN) begin
            cnt_reg <= cnt_reg + IDX_W'(1);
            if (head_match) begin
                hit_reg   <= 1'b1;
                rdata_reg <= head.data;
            end
        end else if (state_reg == ST_INSERT) begin
            // a valid head is the oldest entry and drops off the chain
            evict_reg <= head.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_found_reg     <= hit_reg;
            m_read_data_reg <= (op_reg == OP_LOOKUP && hit_reg) ? rdata_reg : '0;
            m_evicted_reg   <= evict_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_found     = m_found_reg;
    assign m_read_data = m_read_data_reg;
    assign m_evicted   = m_evicted_reg;

endmodule
